@@ hdl/cps_pkg.sv @@
// Shared constants and the pair packet passed along the lane chain.
package cps_pkg;

  localparam int COORD_IN_W = 16;
  localparam int IDX_OUT_W  = 6;
  localparam int DIST_W     = 35;
  localparam int DIM_W      = 4;
  localparam int DIMX_W     = 5;
  localparam int OUT_DATA_W = 48;

  localparam logic [DIST_W-1:0] DIST_LIMIT = '1;

  // lexicographic order of the pair, settled lane by lane
  localparam logic [1:0] LEX_SAME = 2'd0;
  localparam logic [1:0] LEX_LESS = 2'd1;
  localparam logic [1:0] LEX_MORE = 2'd2;

  typedef struct packed {
    logic              v;
    logic              fin;
    logic [1:0]        lex;
    logic [DIST_W-1:0] acc;
  } pair_pkt_t;

endpackage

@@ hdl/cps_lane_cell.sv @@
// One coordinate lane: holds that coordinate of every point, adds its square term.
module cps_lane_cell #(
  parameter int LANE        = 0,
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 16,
  localparam int AW         = $clog2(MAX_POINTS)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [cps_pkg::DIMX_W-1:0] dim_eff,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [COORD_WIDTH-1:0]    wr_data,
  input  cps_pkg::pair_pkt_t        pkt_in,
  input  logic [AW-1:0]             i_in,
  input  logic [AW-1:0]             j_in,
  output cps_pkg::pair_pkt_t        pkt_out,
  output logic [AW-1:0]             i_out,
  output logic [AW-1:0]             j_out
);
  import cps_pkg::*;

  localparam int DFW  = COORD_WIDTH + 1;
  localparam int SQW  = 2 * DFW;
  localparam int SUMW = ((SQW > DIST_W) ? SQW : DIST_W) + 1;

  logic [COORD_WIDTH-1:0] mem [MAX_POINTS];
  logic [COORD_WIDTH-1:0] rd_a, rd_b;
  pair_pkt_t              s1_pkt;
  logic [AW-1:0]          s1_i, s1_j;

  logic                   active;
  logic signed [DFW-1:0]  diff;
  logic [DFW-1:0]         mag;
  logic [SQW-1:0]         sq;
  logic [SUMW-1:0]        sum;
  pair_pkt_t              pkt_next;

  // stage 1: memory write port and two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[i_in];
    rd_b <= mem[j_in];
    s1_i <= i_in;
    s1_j <= j_in;
    if (rst) begin
      s1_pkt <= '0;
    end else begin
      s1_pkt <= pkt_in;
    end
  end

  // stage 2: square of the difference, saturating add, order check
  always_comb begin
    active   = dim_eff > DIMX_W'(LANE);
    diff     = DFW'($signed(rd_a)) - DFW'($signed(rd_b));
    mag      = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
    sq       = SQW'(mag) * SQW'(mag);
    sum      = SUMW'(s1_pkt.acc) + SUMW'(sq);
    pkt_next = s1_pkt;
    if (active) begin
      pkt_next.acc = (sum > SUMW'(DIST_LIMIT)) ? DIST_LIMIT : sum[DIST_W-1:0];
      if (s1_pkt.lex == LEX_SAME) begin
        if ($signed(rd_a) < $signed(rd_b)) begin
          pkt_next.lex = LEX_LESS;
        end else if ($signed(rd_a) > $signed(rd_b)) begin
          pkt_next.lex = LEX_MORE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    i_out <= s1_i;
    j_out <= s1_j;
    if (rst) begin
      pkt_out <= '0;
    end else begin
      pkt_out <= pkt_next;
    end
  end

endmodule

@@ hdl/closest_pair_search_core.sv @@
// Closest-pair search: point loader, pair sequencer, lane chain and best-pair tracker.
//
//  channel   dir  handshake                   contents
//  s_axis    in   tvalid/tready               one coordinate word, tlast on the final one
//  m_axis    out  tvalid/tready               best pair indices, squared distance, error flag
//  apb       in   psel/penable/pwrite/pready  dimension register at byte address 0
//
// Loading takes one word per cycle. After tlast the scan issues one pair per
// cycle, N*(N-1)/2 pairs for N points, then the lane chain drains through each
// lane's read and output registers; the scan rate is set by the single pair issued a cycle.
// s_axis_tready is low from tlast until the result word is taken. Reset
// clears the counters and sequencer; the point memories need no clearing.
module closest_pair_search_core #(
  parameter int MAX_POINTS  = 64,
  parameter int MAX_DIM     = 8,
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // coordinate [15:0]
  input  logic [cps_pkg::COORD_IN_W-1:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_point [5:0], second_point [11:6], squared_distance [46:12], zero [47]
  output logic [cps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // too_few_points [0]
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cps_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(MAX_POINTS + 1);
  localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]             state;
  logic [DIM_W-1:0]       dimension;
  logic [LW-1:0]          loaded, n_pts;
  logic [PW-1:0]          pos;
  logic [AW-1:0]          si, sj;
  logic [DIST_W-1:0]      best_d;
  logic [AW-1:0]          best_first, best_second;
  logic [IDX_OUT_W-1:0]   out_first, out_second;
  logic [DIST_W-1:0]      out_dist;
  logic                   too_few;

  logic                   in_acc, cfg_wr;
  logic [DIMX_W-1:0]      dim_eff, p, p_inc;
  logic                   p_done, full;
  logic [LW-1:0]          loaded_upd;
  logic [31:0]            raw;
  logic [COORD_WIDTH-1:0] coord_st;
  logic                   last_i, last_j, fin;

  pair_pkt_t              chain_pkt [MAX_DIM+1];
  logic [AW-1:0]          chain_i   [MAX_DIM+1];
  logic [AW-1:0]          chain_j   [MAX_DIM+1];
  pair_pkt_t              co;
  logic                   take;
  logic [AW-1:0]          nb_first, nb_second;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(dimension);

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_W'(2);
    end else if (cfg_wr) begin
      dimension <= pwdata[DIM_W-1:0];
    end
  end

  // dimension in force: zero reads as one, clipped at MAX_DIM
  always_comb begin
    if (dimension == '0) begin
      dim_eff = DIMX_W'(1);
    end else if (DIMX_W'(dimension) > DIMX_W'(MAX_DIM)) begin
      dim_eff = DIMX_W'(MAX_DIM);
    end else begin
      dim_eff = DIMX_W'(dimension);
    end
  end

  // loader
  assign s_axis_tready = (state == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign raw           = 32'(s_axis_tdata);
  assign coord_st      = raw[COORD_WIDTH-1:0];
  assign full          = (loaded == LW'(MAX_POINTS));

  always_comb begin
    p          = (DIMX_W'(pos) >= dim_eff) ? dim_eff - DIMX_W'(1) : DIMX_W'(pos);
    p_inc      = p + DIMX_W'(1);
    p_done     = (p_inc >= dim_eff);
    loaded_upd = (!full && p_done) ? loaded + LW'(1) : loaded;
  end

  // pair order: (i,j) with i<j, j running fastest
  assign last_j = (LW'(sj) == n_pts - LW'(1));
  assign last_i = (LW'(si) == n_pts - LW'(2));
  assign fin    = last_i && last_j;

  assign chain_pkt[0] = '{v: (state == ST_SCAN), fin: fin, lex: LEX_SAME, acc: '0};
  assign chain_i[0]   = si;
  assign chain_j[0]   = sj;

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_lane
    cps_lane_cell #(
      .LANE       (k),
      .MAX_POINTS (MAX_POINTS),
      .COORD_WIDTH(COORD_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .dim_eff(dim_eff),
      .wr_en  (in_acc && !full && (p == DIMX_W'(k))),
      .wr_addr(loaded[AW-1:0]),
      .wr_data(coord_st),
      .pkt_in (chain_pkt[k]),
      .i_in   (chain_i[k]),
      .j_in   (chain_j[k]),
      .pkt_out(chain_pkt[k+1]),
      .i_out  (chain_i[k+1]),
      .j_out  (chain_j[k+1])
    );
  end

  // best-pair tracker at the end of the chain; a tie lets the later pair win
  assign co   = chain_pkt[MAX_DIM];
  assign take = co.v && (co.acc <= best_d);

  always_comb begin
    nb_first  = best_first;
    nb_second = best_second;
    if (take && co.lex == LEX_LESS) begin
      nb_first  = chain_i[MAX_DIM];
      nb_second = chain_j[MAX_DIM];
    end else if (take && co.lex == LEX_MORE) begin
      nb_first  = chain_j[MAX_DIM];
      nb_second = chain_i[MAX_DIM];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_d      <= '0;
      best_first  <= '0;
      best_second <= '0;
    end else if (state == ST_LOAD && in_acc && s_axis_tlast) begin
      best_d      <= DIST_LIMIT;
      best_first  <= '0;
      best_second <= '0;
    end else begin
      if (take) begin
        best_d <= co.acc;
      end
      best_first  <= nb_first;
      best_second <= nb_second;
    end
    if (state == ST_LOAD && in_acc && s_axis_tlast) begin
      si          <= '0;
      sj          <= AW'(1);
      n_pts       <= loaded_upd;
      out_first   <= '0;
      out_second  <= '0;
      out_dist    <= '0;
      too_few     <= (loaded_upd < LW'(2));
    end
    if (state == ST_SCAN && !fin) begin
      if (last_j) begin
        si <= si + AW'(1);
        sj <= AW'(LW'(si) + LW'(2));
      end else begin
        sj <= sj + AW'(1);
      end
    end
    if (co.v && co.fin) begin
      out_first  <= IDX_OUT_W'(nb_first);
      out_second <= IDX_OUT_W'(nb_second);
      out_dist   <= take ? co.acc : best_d;
    end
  end

  // sequencer and load counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      loaded <= '0;
      pos    <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (s_axis_tlast) begin
              loaded <= '0;
              pos    <= '0;
              state  <= (loaded_upd < LW'(2)) ? ST_OUT : ST_SCAN;
            end else if (!full) begin
              loaded <= loaded_upd;
              pos    <= p_done ? '0 : PW'(p_inc);
            end
          end
        end
        ST_SCAN: begin
          if (fin) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (co.v && co.fin) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {1'b0, out_dist, out_second, out_first};
  assign m_axis_tuser  = too_few;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("loader open while result pending");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error result carries data");

  a_chain_in_scan: assert property (@(posedge clk) disable iff (rst)
    co.v |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("pair leaves chain outside scan");

  a_fin_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && fin) |=> (state == ST_DRAIN))
    else $error("scan did not stop after last pair");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the closest-pair search core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cps_pkg::*;

  localparam int NPTS_MAX  = 64;
  localparam int NDIM_MAX  = 8;
  localparam int STALL_LIM = 20000;
  localparam logic [2:0] DIM_ADDR = 3'd0;

  typedef struct packed {
    logic [15:0] coord;
    logic        last;
  } coord_word_t;

  typedef struct packed {
    logic [5:0]        first_pt;
    logic [5:0]        second_pt;
    logic [DIST_W-1:0] sq_dist;
    logic              too_few;
  } pair_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  closest_pair_search_core u_top (.*);

  always #6 clk = ~clk;

  // predictor state
  logic signed [15:0] pt_store [NPTS_MAX][NDIM_MAX];
  int unsigned n_loaded, coord_pos, dim_reg;

  coord_word_t  word_q [$];
  pair_result_t pair_q [$];
  int  mismatches, accepted_words;
  int  stall_cnt;
  bit  stim_done;
  bit  gap_en_tx, gap_en_rx;

  function automatic logic [DIST_W-1:0] pair_dist(int a, int b, int d);
    longint acc;
    longint diff;
    acc = 0;
    for (int k = 0; k < d; k++) begin
      diff = longint'(pt_store[a][k]) - longint'(pt_store[b][k]);
      acc += diff * diff;
    end
    return acc[DIST_W-1:0];
  endfunction

  // closest pair of the set just closed; ties go to the later pair
  function automatic pair_result_t scan_set(int n, int d);
    pair_result_t r;
    logic [DIST_W-1:0] best, dd;
    r = '0;
    if (n < 2) begin
      r.too_few = 1'b1;
      return r;
    end
    best = pair_dist(0, 1, d);
    for (int i = 0; i < n - 1; i++)
      for (int j = i + 1; j < n; j++) begin
        dd = pair_dist(i, j, d);
        if (dd <= best) begin
          best = dd;
          for (int l = 0; l < d; l++) begin
            if (pt_store[i][l] > pt_store[j][l]) begin
              r.first_pt = 6'(j); r.second_pt = 6'(i); break;
            end
            if (pt_store[i][l] < pt_store[j][l]) begin
              r.first_pt = 6'(i); r.second_pt = 6'(j); break;
            end
          end
        end
      end
    r.sq_dist = best;
    return r;
  endfunction

  function automatic void load_word(coord_word_t w);
    int d;
    d = (dim_reg == 0) ? 1 : (dim_reg > NDIM_MAX ? NDIM_MAX : dim_reg);
    if (n_loaded < NPTS_MAX) begin
      if (coord_pos >= d) coord_pos = d - 1;
      pt_store[n_loaded][coord_pos] = w.coord;
      if (coord_pos + 1 >= d) begin
        coord_pos = 0;
        n_loaded++;
      end else begin
        coord_pos++;
      end
    end
    if (w.last) begin
      pair_q.push_back(scan_set(n_loaded, d));
      n_loaded = 0;
      coord_pos = 0;
    end
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // driver: one word per handshake, random gaps when enabled
  int tx_gap;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        load_word(word_q.pop_front());
        accepted_words++;
        if (gap_en_tx) tx_gap = gap_len();
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (tx_gap > 0 || word_q.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= word_q[0].coord;
          s_axis_tlast  <= word_q[0].last;
        end
      end
    end
  end

  // monitor and receive-side stalls
  pair_result_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.first_pt  = m_axis_tdata[5:0];
        got.second_pt = m_axis_tdata[11:6];
        got.sq_dist   = m_axis_tdata[46:12];
        got.too_few   = m_axis_tuser;
        if (pair_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", got);
        end else begin
          want = pair_q.pop_front();
          if (got !== want || m_axis_tdata[47] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      m_axis_tready <= gap_en_rx ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done)
      stall_cnt <= 0;
    else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIM) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= DIM_ADDR; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    dim_reg = val[3:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || pair_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // one set of n points at dimension d; span bounds the coordinates
  task automatic push_set(int n, int d, int span, bit extremes);
    coord_word_t w;
    for (int p = 0; p < n; p++)
      for (int k = 0; k < d; k++) begin
        if (extremes) w.coord = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        else if (span >= 32768) w.coord = 16'($urandom);
        else w.coord = 16'($signed($urandom_range(0, 2 * span)) - span);
        w.last = (p == n - 1) && (k == d - 1);
        word_q.push_back(w);
      end
  endtask

  task automatic push_word(logic [15:0] c, logic l);
    coord_word_t w;
    w.coord = c; w.last = l;
    word_q.push_back(w);
  endtask

  int dims [5] = '{1, 2, 8, 3, 5};
  int d, n;

  initial begin
    dim_reg = 2;
    n_loaded = 0; coord_pos = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset dimension, corner sets
    gap_en_tx = 0; gap_en_rx = 0;
    push_word(16'h8000, 1'b1);                        // lone partial point
    push_word(16'h8000, 0); push_word(16'h7fff, 1);   // single point
    push_word(16'h8000, 0); push_word(16'h8000, 0);
    push_word(16'h7fff, 0); push_word(16'h7fff, 1);   // extreme pair
    push_word(16'h0005, 0); push_word(16'h0005, 0);
    push_word(16'h0005, 0); push_word(16'h0005, 1);   // identical pair
    push_word(16'h0001, 0); push_word(16'h0002, 0);
    push_word(16'h0001, 0); push_word(16'h0002, 0);
    push_word(16'h0003, 0); push_word(16'h0003, 0);
    push_word(16'h0009, 1);                           // identical + partial tail
    wait_idle();
    apb_write(8);
    push_set(2, 8, 0, 1'b1);                          // max dimension extremes
    wait_idle();
    apb_write(0);                                     // treated as one
    push_word(16'h0002, 0); push_word(16'h0004, 0); push_word(16'h0003, 1); // tie
    wait_idle();
    apb_write(15);                                    // clamped to max
    push_set(3, 8, 100, 1'b0);
    wait_idle();

    // random: overfull sets, mixed dimensions, gaps on both sides
    gap_en_tx = 1; gap_en_rx = 1;
    for (int ph = 0; ph < 5; ph++) begin
      apb_write(dims[ph]);
      d = dims[ph];
      if (ph == 0) push_set(70, d, 32768, 1'b0);     // store overflow
      for (int s = 0; s < 5; s++) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        if (n == 0) push_word(16'($urandom), 1'b1);
        else push_set(n, d, ($urandom_range(0, 1) ? 32768 : 3), 1'b0);
        gap_en_tx = $urandom_range(0, 3) != 0;
        gap_en_rx = $urandom_range(0, 3) != 0;
      end
      wait_idle();
    end

    stim_done = 1;
    if (mismatches == 0 && pair_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ closest_pair_search_core.f @@
hdl/cps_pkg.sv
hdl/cps_lane_cell.sv
hdl/closest_pair_search_core.sv
tb/testbench.sv
